### hw/rtl/arm_thumb_relocation_patch_assert.svh
// ----------------------------------------------------------------------------
// arm thumb relocation patch assertion macros
// concurrent assertion shorthands used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef ARM_THUMB_RELOCATION_PATCH_ASSERT_SVH
`define ARM_THUMB_RELOCATION_PATCH_ASSERT_SVH

// same-cycle implication
`define ARP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// types and codes shared by the relocation patch pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  localparam logic [7:0] OP_ABS32    = 8'd2;
  localparam logic [7:0] OP_THM_CALL = 8'd10;
  localparam logic [7:0] OP_THM_MOVW = 8'd47;
  localparam logic [7:0] OP_THM_MOVT = 8'd48;
  localparam logic [3:0] SYM_FUNC    = 4'd2;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_ABS  = 3'd1;
  localparam logic [2:0] KIND_CALL = 3'd2;
  localparam logic [2:0] KIND_MOVW = 3'd3;
  localparam logic [2:0] KIND_MOVT = 3'd4;

  typedef struct packed {
    logic [7:0]  op;
    logic [31:0] symbol_addr;
    logic [3:0]  sym_type;
    logic [31:0] section_addr;
    logic [31:0] rel_offset;
    logic [31:0] orig_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] patched_word;
    logic        status;
  } out_item_t;

  // after decode
  typedef struct packed {
    logic [2:0]  kind;
    logic        thumb;
    logic [31:0] symbol;
    logic [31:0] addend;
    logic [31:0] place;
    logic [31:0] word;
  } dec_t;

  // after the symbol add
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] sum;
    logic [31:0] place;
    logic [31:0] word;
  } sum_t;

endpackage

`default_nettype wire

### hw/rtl/arm_thumb_relocation_patch.sv
// ----------------------------------------------------------------------------
// arm_thumb_relocation_patch
// three-stage pipeline that patches one elf arm/thumb relocation per item
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_ready carry one relocation (type, symbol, symbol type,
//   section address, offset, original word) per transfer; out_valid/out_ready
//   carry the patched word and a status bit (1 = unsupported type, word
//   returned unchanged).
//   out_valid rises once the item has been registered by the decode, add
//   and insert stages in turn; a stall can hold it in any stage. one item is
//   accepted every cycle while the output is taken; the stages are decode
//   with place add, symbol add, and place subtract with field insert.
//   each stage has its own valid bit and loads when it is empty or when the
//   next stage loads, so bubbles close up and a receiver stall fills the
//   three stages before in_ready drops; nothing is lost or repeated.
//   reset (rst_n low, synchronous) empties the pipeline; there is no
//   other state and no configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_thumb_relocation_patch (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire arp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output arp_pkg::out_item_t      out_data
);
  import arp_pkg::*;

`include "arm_thumb_relocation_patch_assert.svh"

  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;
  logic sum_valid;
  logic sum_ready;
  sum_t sum_data;

  arp_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (dec_valid),
    .dn_ready (dec_ready),
    .dn_data  (dec_data)
  );

  arp_add u_add (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (sum_valid),
    .dn_ready (sum_ready),
    .dn_data  (sum_data)
  );

  arp_insert u_insert (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sum_valid),
    .up_ready (sum_ready),
    .up_data  (sum_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

  // input back-pressure only when every stage holds an item
  `ARP_ASSERT_NOW(a_full_when_blocked, clk, rst_n, !in_ready,
    dec_valid && sum_valid && out_valid, "in_ready low with an empty stage")

  // a stalled decode stage keeps its item
  `ARP_ASSERT_NEXT(a_dec_hold, clk, rst_n, dec_valid && !dec_ready,
    dec_valid && $stable(dec_data), "decode stage lost or changed a stalled item")

  // an accepted transfer lands in the decode stage
  `ARP_ASSERT_NEXT(a_in_lands, clk, rst_n, in_valid && in_ready,
    dec_valid, "input transfer did not reach the decode stage")

endmodule

`default_nettype wire

### hw/rtl/arp_decode.sv
// ----------------------------------------------------------------------------
// arp_decode
// first stage: classifies the type, extracts the addend, forms the place
// ----------------------------------------------------------------------------
`default_nettype none

module arp_decode (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire arp_pkg::in_item_t up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output arp_pkg::dec_t        dn_data
);
  import arp_pkg::*;

  logic        vld_r;
  dec_t        data_r;
  dec_t        data_nxt;
  logic [15:0] h0;
  logic [15:0] h1;
  logic [22:0] call_imm;
  logic [15:0] mov_imm;
  logic        is_func;

  assign h0       = up_data.orig_word[15:0];
  assign h1       = up_data.orig_word[31:16];
  assign call_imm = {h0[10:0], h1[10:0], 1'b0};
  assign mov_imm  = {h0[3:0], h0[10], h1[14:12], h1[7:0]};
  assign is_func  = (up_data.sym_type == SYM_FUNC);

  always_comb begin
    data_nxt        = '0;
    data_nxt.symbol = up_data.symbol_addr;
    data_nxt.word   = up_data.orig_word;
    data_nxt.place  = up_data.section_addr + up_data.rel_offset;
    case (up_data.op)
      OP_ABS32: begin
        data_nxt.kind   = KIND_ABS;
        data_nxt.addend = up_data.orig_word;
      end
      OP_THM_CALL: begin
        data_nxt.kind   = KIND_CALL;
        data_nxt.thumb  = is_func;
        data_nxt.addend = {{9{call_imm[22]}}, call_imm};
      end
      OP_THM_MOVW: begin
        data_nxt.kind   = KIND_MOVW;
        data_nxt.thumb  = is_func;
        data_nxt.addend = {{16{mov_imm[15]}}, mov_imm};
      end
      OP_THM_MOVT: begin
        data_nxt.kind   = KIND_MOVT;
        data_nxt.addend = {{16{mov_imm[15]}}, mov_imm};
      end
      default: begin
        data_nxt.kind   = KIND_NONE;
      end
    endcase
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### hw/rtl/arp_add.sv
// ----------------------------------------------------------------------------
// arp_add
// second stage: adds the addend to the symbol and merges the thumb bit
// ----------------------------------------------------------------------------
`default_nettype none

module arp_add (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire arp_pkg::dec_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output arp_pkg::sum_t      dn_data
);
  import arp_pkg::*;

  logic vld_r;
  sum_t data_r;
  sum_t data_nxt;

  always_comb begin
    data_nxt.kind  = up_data.kind;
    data_nxt.place = up_data.place;
    data_nxt.word  = up_data.word;
    data_nxt.sum   = (up_data.symbol + up_data.addend) | {31'd0, up_data.thumb};
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

### hw/rtl/arp_insert.sv
// ----------------------------------------------------------------------------
// arp_insert
// third stage: subtracts the place for calls and rewrites the word fields
// ----------------------------------------------------------------------------
`default_nettype none

module arp_insert (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire arp_pkg::sum_t up_data,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output arp_pkg::out_item_t dn_data
);
  import arp_pkg::*;

  logic        vld_r;
  out_item_t   data_r;
  out_item_t   data_nxt;
  logic [31:0] branch;
  logic [15:0] imm;
  logic [15:0] h0;
  logic [15:0] h1;

  assign h0     = up_data.word[15:0];
  assign h1     = up_data.word[31:16];
  assign branch = up_data.sum - up_data.place;
  assign imm    = (up_data.kind == KIND_MOVT) ? up_data.sum[31:16] : up_data.sum[15:0];

  always_comb begin
    data_nxt.status = 1'b0;
    case (up_data.kind)
      KIND_ABS: begin
        data_nxt.patched_word = up_data.sum;
      end
      KIND_CALL: begin
        data_nxt.patched_word = {5'b11111, branch[11:1], 5'b11110, branch[22:12]};
      end
      KIND_MOVW, KIND_MOVT: begin
        data_nxt.patched_word = {h1[15], imm[10:8], h1[11:8], imm[7:0],
                                 h0[15:11], imm[11], h0[9:4], imm[15:12]};
      end
      default: begin
        data_nxt.patched_word = up_data.word;
        data_nxt.status       = 1'b1;
      end
    endcase
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire
